// ===== rtl/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
// Holds the table sizes, action and status codes, and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package gha_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int GEN_W      = 32;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOT_COUNT);
    localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};
    localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_SPARE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_STALE   = 2'd2,
        ST_UNALLOC = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // latch the input word, read the top of the free stack
        logic lookup;   // pick the slot, read generation and live bit
        logic commit;   // update state, load the output register
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/gha_ctrl.sv =====
// Controller of the generational handle allocator: sequences take, lookup and commit.
// Owns the input ready and the output valid. Depends on gha_pkg.
`default_nettype none

module gha_ctrl
    import gha_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    output logic o_valid,
    input  wire  i_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_EXEC   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.take   = 1'b0;
        o_cmd.lookup = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                // hold here until the output register can take the word
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_take_then_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> o_cmd.lookup)
        else $error("lookup did not follow take");

    a_lookup_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> (r_state == S_EXEC))
        else $error("lookup not followed by execute");

    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("commit would overwrite a waiting result");

endmodule

`default_nettype wire

// ===== rtl/gha_datapath.sv =====
// Datapath of the generational handle allocator: generation table, live bits, free stack,
// counters and the output register. Depends on gha_pkg; driven by gha_ctrl commands.
`default_nettype none

module gha_datapath
    import gha_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cmd             i_cmd,
    input  wire  [1:0]       i_action,
    input  wire  [IDX_W-1:0] i_handle_index,
    input  wire  [GEN_W-1:0] i_handle_generation,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_out_index,
    output logic [GEN_W-1:0] o_out_generation,
    output logic             o_is_valid
);

    // memories
    logic [GEN_W-1:0] gen_mem   [SLOT_COUNT];
    logic             live_mem  [SLOT_COUNT];
    logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
    logic [GEN_W-1:0] r_gen_q;
    logic             r_live_q;
    logic [IDX_W-1:0] r_stack_q;

    // item and counters
    t_action          r_action;
    logic [IDX_W-1:0] r_idx;
    logic [GEN_W-1:0] r_hgen;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [CNT_W-1:0] r_fresh_count, n_fresh_count;

    // output register
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    logic [GEN_W-1:0] r_out_gen, n_out_gen;
    logic             r_is_valid, n_is_valid;

    logic             is_alloc;
    logic             have_free;
    logic [CNT_W-1:0] stack_top;
    logic [GEN_W-1:0] bumped_gen;
    logic             gen_we;
    logic [GEN_W-1:0] gen_wd;
    logic             live_we;
    logic             live_wd;
    logic             stack_we;

    assign is_alloc   = (r_action == ACT_ALLOC);
    assign have_free  = (r_free_count != '0);
    assign stack_top  = r_free_count - CNT_W'(1);
    assign bumped_gen = (r_gen_q == GEN_MAX) ? GEN_FIRST : r_gen_q + GEN_FIRST;

    // slot for the table read: reused slot, fresh slot, or the handle's own index
    always_comb begin
        if (is_alloc) begin
            n_slot = have_free ? r_stack_q : r_fresh_count[IDX_W-1:0];
        end else begin
            n_slot = r_idx;
        end
    end

    always_comb begin
        n_status      = ST_OK;
        n_out_index   = r_idx;
        n_out_gen     = '0;
        n_is_valid    = 1'b0;
        n_free_count  = r_free_count;
        n_fresh_count = r_fresh_count;
        gen_we        = 1'b0;
        gen_wd        = GEN_FIRST;
        live_we       = 1'b0;
        live_wd       = 1'b1;
        stack_we      = 1'b0;
        if (is_alloc) begin
            if (have_free) begin
                n_out_index  = r_slot;
                n_out_gen    = bumped_gen;
                n_is_valid   = 1'b1;
                n_free_count = stack_top;
                gen_we       = 1'b1;
                gen_wd       = bumped_gen;
                live_we      = 1'b1;
            end else if (r_fresh_count < SLOTS_CNT) begin
                n_out_index   = r_slot;
                n_out_gen     = GEN_FIRST;
                n_is_valid    = 1'b1;
                n_fresh_count = r_fresh_count + CNT_W'(1);
                gen_we        = 1'b1;
                live_we       = 1'b1;
            end else begin
                n_status    = ST_FULL;
                n_out_index = '0;
            end
        end else if (r_hgen == '0) begin
            n_status = ST_STALE;
        end else if ({1'b0, r_idx} >= r_fresh_count) begin
            n_status = ST_UNALLOC;
        end else begin
            n_out_gen = r_gen_q;
            if ((r_gen_q == r_hgen) && r_live_q) begin
                n_is_valid = 1'b1;
                if ((r_action == ACT_FREE) && (r_free_count < SLOTS_CNT)) begin
                    stack_we     = 1'b1;
                    n_free_count = r_free_count + CNT_W'(1);
                    live_we      = 1'b1;
                    live_wd      = 1'b0;
                end
            end else begin
                n_status = ST_STALE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_stack_q <= stack_mem[stack_top[IDX_W-1:0]];
        end
        if (i_cmd.commit && stack_we) begin
            stack_mem[r_free_count[IDX_W-1:0]] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_gen_q <= gen_mem[n_slot];
        end
        if (i_cmd.commit && gen_we) begin
            gen_mem[r_slot] <= gen_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_live_q <= live_mem[n_slot];
        end
        if (i_cmd.commit && live_we) begin
            live_mem[r_slot] <= live_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= t_action'(i_action);
            r_idx    <= i_handle_index;
            r_hgen   <= i_handle_generation;
        end
        if (i_cmd.lookup) begin
            r_slot <= n_slot;
        end
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_out_index <= n_out_index;
            r_out_gen   <= n_out_gen;
            r_is_valid  <= n_is_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count  <= '0;
            r_fresh_count <= '0;
        end else if (i_cmd.commit) begin
            r_free_count  <= n_free_count;
            r_fresh_count <= n_fresh_count;
        end
    end

    assign o_status         = r_status;
    assign o_out_index      = r_out_index;
    assign o_out_generation = r_out_gen;
    assign o_is_valid       = r_is_valid;

    a_free_within_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_fresh_count)
        else $error("free stack deeper than slots ever handed out");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_count <= SLOTS_CNT)
        else $error("high-water mark beyond slot count");

    a_grant_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_alloc && n_is_valid) |-> (n_out_gen != '0))
        else $error("granted a null generation");

endmodule

`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
// Instantiates gha_ctrl and gha_datapath; depends on gha_pkg.
`default_nettype none

// Hands out handles made of a slot index and a generation. Allocate reuses the most recently
// freed slot with its generation bumped (wrapping from all ones back to 1) or else takes the
// next never-used slot with generation 1, and reports table full when neither exists. Free
// and check accept a handle only when its generation is non-zero, its index has been handed
// out before, its generation equals the stored one and the slot is live; a successful free
// pushes the slot onto the free stack. Every input word yields exactly one result word.
// An item passes through take, lookup and update: the accepting edge latches the word and reads
// the top of the free stack, the next edge reads the generation table and live bit, and the
// update edge, held while a result still waits, updates state and loads the output register.
// The result can be taken from the edge after the update on, and the next word is accepted at
// that same edge at the earliest, once the last word is through. The output register lets the
// next word be accepted while a result still waits; a new result waits in the update step
// until the previous one is taken. No clearing pass runs after reset: the high-water mark
// keeps every value that is used within slots already written.

module generational_handle_allocator
    import gha_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [1:0]       i_action,
    input  wire  [IDX_W-1:0] i_handle_index,
    input  wire  [GEN_W-1:0] i_handle_generation,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_out_index,
    output logic [GEN_W-1:0] o_out_generation,
    output logic             o_is_valid
);

    t_cmd cmd;

    // sequence take, lookup and commit; hold the commit while the output word waits
    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // tables, free stack, counters and the output register
    gha_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_action            (i_action),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_is_valid          (o_is_valid)
    );

endmodule

`default_nettype wire

// ===== bench/generational_handle_allocator_test.sv =====
// Self-checking testbench for the generational handle allocator.
// Predicts every result word from its own copy of the slot table and free stack.
// Depends on gha_pkg and generational_handle_allocator.

module generational_handle_allocator_test;
    import gha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 26;
    localparam int STALL_LIMIT = 1000;  // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 16;    // settle time after the last result word
    localparam int PRINT_CAP   = 100;
    localparam int DUE_IDX_W   = 3;     // at most two predictions are ever outstanding
    localparam int DUE_DEPTH   = 1 << DUE_IDX_W;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] gen;
        logic             valid;
    } t_handle_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [1:0]       i_action = ACT_CHECK;
    logic [IDX_W-1:0] i_handle_index = '0;
    logic [GEN_W-1:0] i_handle_generation = '0;
    logic             i_ready = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [IDX_W-1:0] o_out_index;
    logic [GEN_W-1:0] o_out_generation;
    logic             o_is_valid;

    generational_handle_allocator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_action            (i_action),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_is_valid          (o_is_valid)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the allocator state, advanced once per accepted input word.
    logic [GEN_W-1:0] slot_gen    [SLOT_COUNT];
    logic             slot_live   [SLOT_COUNT];
    logic [IDX_W-1:0] freed_slots [SLOT_COUNT];
    logic [CNT_W-1:0] freed_depth = '0;
    logic [CNT_W-1:0] high_water  = '0;

    // Predictions waiting for their result word, oldest at due_rd.
    t_handle_reply    due_words [DUE_DEPTH];
    logic [DUE_IDX_W:0] due_wr = '0;
    logic [DUE_IDX_W:0] due_rd = '0;

    t_handle_reply want_reply;
    int            error_count = 0;
    int            result_seq  = 0;
    int            stall_cycles = 0;
    bit            calm = 1'b0;   // high: neither side idles

    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_gen[s]  = '0;
            slot_live[s] = 1'b0;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("mismatch at %0t ns, result %0d: %s", $time, result_seq, what);
        error_count++;
    endtask

    // Apply one input word to the shadow state and return the result word it must produce.
    function automatic t_handle_reply apply_handle_op(input t_action act,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [GEN_W-1:0] gen);
        t_handle_reply    r;
        logic [IDX_W-1:0] slot;
        logic [GEN_W-1:0] grant;
        logic [GEN_W-1:0] stored;
        r.status = ST_OK;
        r.index  = idx;
        r.gen    = '0;
        r.valid  = 1'b0;
        if (act == ACT_ALLOC) begin
            r.index = '0;
            if (freed_depth != '0) begin
                // Reuse the most recently freed slot; wrap the generation past all ones to 1.
                freed_depth = freed_depth - CNT_W'(1);
                slot  = freed_slots[freed_depth[IDX_W-1:0]];
                grant = (slot_gen[slot] == GEN_MAX) ? GEN_FIRST : slot_gen[slot] + GEN_FIRST;
            end else if (high_water < SLOTS_CNT) begin
                slot       = high_water[IDX_W-1:0];
                high_water = high_water + CNT_W'(1);
                grant      = GEN_FIRST;
            end else begin
                r.status = ST_FULL;
                return r;
            end
            slot_gen[slot]  = grant;
            slot_live[slot] = 1'b1;
            r.index = slot;
            r.gen   = grant;
            r.valid = 1'b1;
            return r;
        end
        // Free, check and the spare code all start with the handle tests.
        if (gen == '0) begin
            r.status = ST_STALE;
            return r;
        end
        if ({1'b0, idx} >= high_water) begin
            r.status = ST_UNALLOC;
            return r;
        end
        stored = slot_gen[idx];
        r.gen  = stored;
        if (stored != gen || !slot_live[idx]) begin
            r.status = ST_STALE;
            return r;
        end
        if (act == ACT_FREE && freed_depth < SLOTS_CNT) begin
            freed_slots[freed_depth[IDX_W-1:0]] = idx;
            freed_depth     = freed_depth + CNT_W'(1);
            slot_live[idx]  = 1'b0;
        end
        r.valid = 1'b1;
        return r;
    endfunction

    // Check each result word against the oldest prediction, then predict for the word
    // accepted at this edge. Lookup and update lie between a word and its own result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_ready) begin
                if (due_wr == due_rd) begin
                    report_mismatch("result word with no prediction outstanding");
                end else begin
                    want_reply = due_words[due_rd[DUE_IDX_W-1:0]];
                    due_rd     = due_rd + (DUE_IDX_W + 1)'(1);
                    if (o_status !== want_reply.status)
                        report_mismatch($sformatf("status %0d, predicted %s",
                                                  o_status, want_reply.status.name()));
                    if (o_out_index !== want_reply.index)
                        report_mismatch($sformatf("index %0d, predicted %0d",
                                                  o_out_index, want_reply.index));
                    if (o_out_generation !== want_reply.gen)
                        report_mismatch($sformatf("generation %0h, predicted %0h",
                                                  o_out_generation, want_reply.gen));
                    if (o_is_valid !== want_reply.valid)
                        report_mismatch($sformatf("is_valid %0b, predicted %0b",
                                                  o_is_valid, want_reply.valid));
                end
                result_seq++;
            end
            if (i_valid && o_ready === 1'b1) begin
                due_words[due_wr[DUE_IDX_W-1:0]] = apply_handle_op(t_action'(i_action),
                                                                   i_handle_index,
                                                                   i_handle_generation);
                due_wr = due_wr + (DUE_IDX_W + 1)'(1);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall about a quarter of the cycles unless calm.
    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Drive one input word starting at a falling edge; return at the falling edge after it
    // is taken, when the shadow state already holds its effect.
    task automatic send_word(input t_action act, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] gen);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_action            <= act;
        i_handle_index      <= idx;
        i_handle_generation <= gen;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    function automatic int pick_live_slot();
        int n;
        int start;
        int s;
        int k;
        n = int'(high_water);
        if (n == 0) return -1;
        start = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
            s = (start + k) % n;
            if (slot_live[s]) return s;
        end
        return -1;
    endfunction

    function automatic logic [GEN_W-1:0] random_gen();
        return {$urandom()} & GEN_MAX;
    endfunction

    function automatic logic [IDX_W-1:0] random_idx();
        return IDX_W'($urandom_range(0, SLOT_COUNT - 1));
    endfunction

    // Broken or foreign handles: null, stale, off-by-one, random, never handed out.
    task automatic send_noise();
        t_action          act;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        act = t_action'($urandom_range(ACT_FREE, ACT_SPARE));
        if (high_water != '0 && $urandom_range(0, 2) != 0)
            idx = IDX_W'($urandom_range(0, int'(high_water) - 1));
        else
            idx = random_idx();
        case ($urandom_range(0, 4))
            0: gen = '0;
            1: gen = slot_gen[idx];
            2: gen = slot_gen[idx] + GEN_FIRST;
            3: gen = slot_gen[idx] - GEN_FIRST;
            default: gen = random_gen();
        endcase
        send_word(act, idx, gen);
    endtask

    task automatic send_live(input t_action act);
        int s;
        s = pick_live_slot();
        if (s < 0)
            send_word(ACT_ALLOC, random_idx(), random_gen());
        else
            send_word(act, s[IDX_W-1:0], slot_gen[s]);
    endtask

    // Walk the corner cases by hand from a fresh reset.
    task automatic test_directed_cases();
        send_word(ACT_CHECK, '0, GEN_FIRST);              // nothing handed out yet
        send_word(ACT_CHECK, '0, '0);                     // null handle
        send_word(ACT_ALLOC, {IDX_W{1'b1}}, GEN_MAX);     // fields ignored on allocate
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_CHECK, 10'd0, GEN_FIRST);
        send_word(ACT_CHECK, {IDX_W{1'b1}}, GEN_MAX);     // top index, never handed out
        send_word(ACT_CHECK, 10'd1, GEN_MAX);             // wrong generation
        send_word(ACT_FREE,  10'd0, '0);                  // null free
        send_word(ACT_FREE,  10'd1, GEN_FIRST);
        send_word(ACT_FREE,  10'd1, GEN_FIRST);           // double free
        send_word(ACT_CHECK, 10'd1, GEN_FIRST);           // freed slot
        send_word(ACT_SPARE, 10'd0, GEN_FIRST);           // spare code acts as check
        send_word(ACT_SPARE, 10'd2, 32'd2);
        send_word(ACT_ALLOC, '0, '0);                     // reuse slot 1 at generation 2
        send_word(ACT_FREE,  10'd0, GEN_FIRST);
        send_word(ACT_FREE,  10'd2, GEN_FIRST);
        send_word(ACT_ALLOC, '0, '0);                     // last freed comes back first
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, '0);                     // stack empty, fresh slot
        send_word(ACT_FREE,  10'd1, GEN_FIRST);           // stale generation
        send_word(ACT_FREE,  10'd1, 32'd2);
    endtask

    // Mixed traffic on a small working set, with a calm stretch in the middle.
    task automatic test_handle_churn(input int count);
        int k;
        int roll;
        for (k = 0; k < count; k++) begin
            calm = (k >= count / 3 && k < 2 * count / 3);
            roll = $urandom_range(0, 99);
            if (roll < 35)
                send_word(ACT_ALLOC, random_idx(), random_gen());
            else if (roll < 60)
                send_live(ACT_FREE);
            else if (roll < 80)
                send_live($urandom_range(0, 1) ? ACT_CHECK : ACT_SPARE);
            else
                send_noise();
        end
        calm = 1'b0;
    endtask

    // Allocate until every slot is live, then push against the full table.
    task automatic test_table_full();
        int s;
        while (!(high_water == SLOTS_CNT && freed_depth == '0)) begin
            if ($urandom_range(0, 99) < 85)
                send_word(ACT_ALLOC, random_idx(), random_gen());
            else
                send_live(ACT_CHECK);
        end
        repeat (3) send_word(ACT_ALLOC, '0, '0);
        s = pick_live_slot();
        send_word(ACT_FREE, s[IDX_W-1:0], slot_gen[s]);
        send_word(ACT_CHECK, s[IDX_W-1:0], slot_gen[s]);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, '0);
    endtask

    // Free heavily from the full table and reuse slots from a deep free stack.
    task automatic test_drain_and_reuse(input int count);
        int k;
        int roll;
        for (k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                send_live(ACT_FREE);
            else if (roll < 70)
                send_word(ACT_ALLOC, random_idx(), random_gen());
            else if (roll < 80)
                send_live(ACT_CHECK);
            else
                send_noise();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_handle_churn(400);
        test_table_full();
        test_drain_and_reuse(500);

        // Drop valid, wait for every prediction to be matched, then let the pipe settle.
        i_valid <= 1'b0;
        while (due_wr != due_rd) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (due_wr != due_rd)
            report_mismatch("predictions left without a result word");

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gha_pkg.sv
rtl/gha_ctrl.sv
rtl/gha_datapath.sv
rtl/generational_handle_allocator.sv
bench/generational_handle_allocator_test.sv
